// ===== sv/pulse_width_packet_transmitter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-width packet transmitter
// Concurrent checks sampled on clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_PACKET_TRANSMITTER_MACROS_SVH
`define PULSE_WIDTH_PACKET_TRANSMITTER_MACROS_SVH

// same-cycle implication
`define PWPT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PWPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pwpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpt_pkg
// Shared types, constants and helpers of the pulse-width packet transmitter.
// ----------------------------------------------------------------------------
package pwpt_pkg;

   localparam int REPEAT_COUNT_DEF = 3;
   localparam int LEAD_TICKS       = 3;
   localparam int TAIL_TICKS       = 4;
   localparam int BITS_PER_BYTE    = 8;
   localparam int CNT_W            = 5;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 5;

   localparam logic [3:0] HIGH_LEN_RST     = 4'd1;
   localparam logic [3:0] ZERO_LOW_LEN_RST = 4'd1;
   localparam logic [3:0] ONE_LOW_LEN_RST  = 4'd4;
   localparam logic [4:0] BYTE_GAP_LEN_RST = 5'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LEN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW_LEN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_GAP_LEN = 2'd3;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] address;
      logic [7:0] data_byte;
   } q_entry_type;

   // a zero length acts as one tick
   function automatic logic [CNT_W-1:0] len_of(input logic [CNT_W-1:0] v);
      return (v == '0) ? CNT_W'(1) : v;
   endfunction

endpackage

// ===== sv/pwpt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpt request and response channels
// Valid/ready channels carrying tick/start items in and line results out.
// ----------------------------------------------------------------------------
interface pwpt_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] address;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output address, output data_byte,
                   input ready);
   modport sink   (input valid, input kind, input address, input data_byte,
                   output ready);
endinterface

interface pwpt_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic drive_enable;
   logic busy_res;
   logic start_rejected;

   modport source (output valid, output line_level, output drive_enable,
                   output busy_res, output start_rejected, input ready);
   modport sink   (input valid, input line_level, input drive_enable,
                   input busy_res, input start_rejected, output ready);
endinterface

// ===== sv/pwpt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpt_front
// Accepts request transactions, classifies them and queues them (two deep).
// ----------------------------------------------------------------------------
module pwpt_front
   import pwpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pwpt_req_if.sink    req_chan,
   output logic        q_valid,
   output q_entry_type q_entry,
   input  logic        q_pop
);

`include "pulse_width_packet_transmitter_macros.svh"

   q_entry_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   q_entry_type push_entry;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != 2'd0);
   assign q_entry        = slot_ff[rd_ptr_ff];

   always_comb begin
      push_entry.op        = req_chan.kind ? OP_START : OP_TICK;
      push_entry.address   = req_chan.address;
      push_entry.data_byte = req_chan.data_byte;
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `PWPT_ASSERT_IMPL(a_count_range, 1'b1, count_ff != 2'd3, "queue count out of range")
   `PWPT_ASSERT_IMPL(a_pop_nonempty, q_pop, count_ff != 2'd0, "pop from empty queue")
   `PWPT_ASSERT_NEXT(a_full_after_push, push && !q_pop && count_ff == 2'd1,
                     !req_chan.ready, "queue should be full")

endmodule

// ===== sv/pwpt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwpt_back
// Runs the packet sequencer, one queued transaction per cycle unless the
// response channel stalls, into a registered response.
// ----------------------------------------------------------------------------
module pwpt_back
   import pwpt_pkg::*;
#(
   parameter int REPEAT_COUNT = REPEAT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  q_entry_type           q_entry,
   output logic                  q_pop,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   pwpt_rsp_if.source            rsp_chan
);

`include "pulse_width_packet_transmitter_macros.svh"

   localparam int REP_W = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;
   localparam logic [REP_W-1:0] REP_LAST = REP_W'(REPEAT_COUNT - 1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_PRE, PH_LEAD, PH_BITHI, PH_BITLO,
      PH_ENDHI, PH_GAP, PH_CLOSEHI, PH_CLOSELO, PH_TAIL
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       grp_ff, grp_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic [2:0]       bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       data_ff, data_in;
   logic             level_ff, level_in;
   logic             driven_ff, driven_in;
   logic [3:0]       high_len_ff, high_len_in;
   logic [3:0]       zero_len_ff, zero_len_in;
   logic [3:0]       one_len_ff, one_len_in;
   logic [4:0]       gap_len_ff, gap_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             busy_ff, busy_in;
   logic             rej_ff, rej_in;
   logic [7:0]       cur_byte;
   logic [CNT_W-1:0] high_ticks, zero_ticks, one_ticks, gap_ticks;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.line_level     = level_ff;
   assign rsp_chan.drive_enable   = driven_ff;
   assign rsp_chan.busy_res       = busy_ff;
   assign rsp_chan.start_rejected = rej_ff;

   assign high_ticks = len_of(CNT_W'(high_len_ff));
   assign zero_ticks = len_of(CNT_W'(zero_len_ff));
   assign one_ticks  = len_of(CNT_W'(one_len_ff));
   assign gap_ticks  = len_of(gap_len_ff);

   always_comb begin
      case (grp_ff)
         2'd0:    cur_byte = 8'h00;
         2'd1:    cur_byte = addr_ff;
         2'd2:    cur_byte = data_ff;
         default: cur_byte = 8'hFF;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      grp_in       = grp_ff;
      rep_in       = rep_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      level_in     = level_ff;
      driven_in    = driven_ff;
      high_len_in  = high_len_ff;
      zero_len_in  = zero_len_ff;
      one_len_in   = one_len_ff;
      gap_len_in   = gap_len_ff;
      busy_in      = busy_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_LEN:     high_len_in = csr_wdata[3:0];
            CSR_ZERO_LOW_LEN: zero_len_in = csr_wdata[3:0];
            CSR_ONE_LOW_LEN:  one_len_in  = csr_wdata[3:0];
            CSR_BYTE_GAP_LEN: gap_len_in  = csr_wdata;
            default: ;
         endcase
      end

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
         rej_in       = 1'b0;
         if (q_entry.op == OP_START) begin
            busy_in = 1'b1;
            if (phase_ff != PH_IDLE) begin
               rej_in = 1'b1;
            end else begin
               addr_in  = q_entry.address;
               data_in  = q_entry.data_byte;
               phase_in = PH_PRE;
               cnt_in   = CNT_W'(LEAD_TICKS);
            end
         end else if (phase_ff == PH_IDLE) begin
            level_in  = 1'b0;
            driven_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            case (phase_ff)
               PH_PRE, PH_TAIL: begin
                  level_in  = 1'b0;
                  driven_in = 1'b0;
               end
               PH_BITHI, PH_ENDHI, PH_CLOSEHI: begin
                  level_in  = 1'b1;
                  driven_in = 1'b1;
               end
               default: begin
                  level_in  = 1'b0;
                  driven_in = 1'b1;
               end
            endcase
            if (cnt_ff > CNT_W'(1)) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               // advance to the next segment of the packet
               case (phase_ff)
                  PH_PRE: begin
                     phase_in = PH_LEAD;
                     cnt_in   = CNT_W'(LEAD_TICKS);
                  end
                  PH_LEAD: begin
                     grp_in   = 2'd0;
                     rep_in   = '0;
                     bit_in   = 3'd0;
                     phase_in = PH_BITHI;
                     cnt_in   = high_ticks;
                  end
                  PH_BITHI: begin
                     phase_in = PH_BITLO;
                     cnt_in   = cur_byte[bit_ff] ? one_ticks : zero_ticks;
                  end
                  PH_BITLO: begin
                     if (bit_ff != 3'(BITS_PER_BYTE - 1)) begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_BITHI;
                     end else begin
                        phase_in = PH_ENDHI;
                     end
                     cnt_in = high_ticks;
                  end
                  PH_ENDHI: begin
                     phase_in = PH_GAP;
                     cnt_in   = gap_ticks;
                  end
                  PH_GAP: begin
                     cnt_in = high_ticks;
                     if (grp_ff == 2'd3 && rep_ff == REP_LAST) begin
                        phase_in = PH_CLOSEHI;
                     end else begin
                        if (rep_ff == REP_LAST) begin
                           rep_in = '0;
                           grp_in = grp_ff + 2'd1;
                        end else begin
                           rep_in = rep_ff + REP_W'(1);
                        end
                        bit_in   = 3'd0;
                        phase_in = PH_BITHI;
                     end
                  end
                  PH_CLOSEHI: begin
                     phase_in = PH_CLOSELO;
                     cnt_in   = zero_ticks;
                  end
                  PH_CLOSELO: begin
                     phase_in = PH_TAIL;
                     cnt_in   = CNT_W'(TAIL_TICKS);
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     cnt_in   = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         grp_ff       <= 2'd0;
         rep_ff       <= '0;
         bit_ff       <= 3'd0;
         cnt_ff       <= '0;
         addr_ff      <= 8'h00;
         data_ff      <= 8'h00;
         level_ff     <= 1'b0;
         driven_ff    <= 1'b0;
         high_len_ff  <= HIGH_LEN_RST;
         zero_len_ff  <= ZERO_LOW_LEN_RST;
         one_len_ff   <= ONE_LOW_LEN_RST;
         gap_len_ff   <= BYTE_GAP_LEN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         grp_ff       <= grp_in;
         rep_ff       <= rep_in;
         bit_ff       <= bit_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         level_ff     <= level_in;
         driven_ff    <= driven_in;
         high_len_ff  <= high_len_in;
         zero_len_ff  <= zero_len_in;
         one_len_ff   <= one_len_in;
         gap_len_ff   <= gap_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      busy_ff <= busy_in;
      rej_ff  <= rej_in;
   end

   `PWPT_ASSERT_IMPL(a_idle_no_count, phase_ff == PH_IDLE, cnt_ff == '0,
                     "countdown left running while idle")
   `PWPT_ASSERT_IMPL(a_reject_busy, rsp_valid_ff && rej_ff, busy_ff,
                     "rejected start reported without busy")
   `PWPT_ASSERT_IMPL(a_released_low, !driven_ff, !level_ff,
                     "released pin reported high")

endmodule

// ===== sv/pulse_width_packet_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_packet_transmitter
// Single-wire pulse-width packet transmitter advanced by tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per item: kind 0 is one line tick,
//   kind 1 starts a packet with address and data_byte. rsp_chan returns one
//   result per request: the line level and drive enable for that tick, busy
//   and a flag for a start that arrived while a packet was running.
//   csr_* writes the four length registers; write only while idle.
//   An accepted request is written into the queue and then popped into the
//   registered response. The block sustains one transaction per cycle
//   while rsp_chan is not stalled, set by the back-end sequencer, which
//   retires one queued transaction per clock.
//   A two-deep queue separates the front end from the sequencer and the
//   response is registered; when rsp_chan stalls the queue fills and
//   req_chan.ready drops once it holds two transactions.
//   Reset empties the queue, releases the line, returns the sequencer to
//   idle and loads the length registers with their defaults.
// ----------------------------------------------------------------------------
module pulse_width_packet_transmitter
   import pwpt_pkg::*;
#(
   parameter int REPEAT_COUNT = REPEAT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pwpt_req_if.sink              req_chan,
   pwpt_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        q_valid;
   logic        q_pop;
   q_entry_type q_entry;

   pwpt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   pwpt_back #(
      .REPEAT_COUNT (REPEAT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule
